// ===== hdl/swt_pkg.sv =====
`timescale 1ns / 1ps

package swt_pkg;

   localparam int TICK_W    = 63;
   localparam int TASK_ID_W = 8;

   localparam logic [TICK_W-1:0] TICK_ALL_ONES = {TICK_W{1'b1}};

   localparam logic ACT_SLEEP = 1'b0;
   localparam logic ACT_TICK  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   typedef struct packed {
      logic due;
      logic lower;
   } cmp_res_type;

endpackage

// ===== hdl/swt_ram.sv =====
`timescale 1ns / 1ps

module swt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hdl/swt_cmp.sv =====
`timescale 1ns / 1ps

module swt_cmp
   import swt_pkg::*;
(
   input  logic [TICK_W-1:0] wake,
   input  logic [TICK_W-1:0] now,
   input  logic [TICK_W-1:0] floor_val,
   output cmp_res_type       res
);

   // due: wake at or before now; lower: wake below running minimum
   assign res.due   = (wake <= now);
   assign res.lower = (wake < floor_val);

endmodule

// ===== hdl/sleep_wakeup_timer_table_core.sv =====
`timescale 1ns / 1ps

// Sleep word: the result is registered and appears in the cycle after acceptance; a new
// word may start on the next cycle. Tick word: one comparator scans the slot RAM for all
// sleepers, then issues one result per woken task (or a single result), one per cycle.
// A tick word keeps the core busy through the scan and the emission of its results.
// Synchronous reset empties the table and sets earliest wake to all ones; slot RAM
// contents are left as they are. Results cannot be stalled by the receiver.
module sleep_wakeup_timer_table_core
   import swt_pkg::*;
#(
   parameter int SLOTS     = 16,
   parameter int TASK_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_action,
   input  logic [TASK_ID_W-1:0] req_task_id,
   input  logic [TICK_W-1:0]    req_wake_tick,
   input  logic [TICK_W-1:0]    req_now_tick,
   output logic                 rsp_strobe,
   output logic                 rsp_woken_valid,
   output logic [TASK_ID_W-1:0] rsp_woken_task,
   output logic                 rsp_accepted,
   output logic [TICK_W-1:0]    rsp_earliest_wake,
   output logic                 rsp_last
);

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int SLOT_W = TASK_BITS + TICK_W;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [TICK_W-1:0]  next_wake_ff, next_wake_in;
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               pend_ff, pend_in;
   logic [CNT_W-1:0]   keep_ff, keep_in;
   logic [CNT_W-1:0]   nw_ff, nw_in;
   logic [CNT_W-1:0]   em_idx_ff, em_idx_in;
   logic [TICK_W-1:0]  early_ff, early_in;
   logic [TICK_W-1:0]  now_ff, now_in;
   logic               strobe_ff, strobe_in;
   logic               wvalid_ff, wvalid_in;
   logic               acc_ff, acc_in;
   logic               last_ff, last_in;

   logic               s_we, s_re;
   logic [IDX_W-1:0]   s_waddr, s_raddr;
   logic [SLOT_W-1:0]  s_wdata, s_rdata;
   logic               w_we, w_re;
   logic [IDX_W-1:0]   w_waddr, w_raddr;
   logic [TASK_BITS-1:0] w_wdata, w_rdata;

   logic [TASK_BITS-1:0]           s_rd_task;
   logic [TICK_W-1:0]              s_rd_wake;
   logic [TASK_BITS+TASK_ID_W-1:0] id_ext, wk_ext;
   logic [TICK_W-1:0]              cmp_wake, cmp_floor;
   cmp_res_type                    cmp_res;

   assign s_rd_task = s_rdata[SLOT_W-1 -: TASK_BITS];
   assign s_rd_wake = s_rdata[TICK_W-1:0];
   assign id_ext    = {{TASK_BITS{1'b0}}, req_task_id};
   assign wk_ext    = {{TASK_ID_W{1'b0}}, w_rdata};

   swt_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_en   (s_re),
      .rd_addr (s_raddr),
      .rd_data (s_rdata)
   );

   swt_ram #(.WIDTH(TASK_BITS), .DEPTH(SLOTS)) u_woken_ram (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (w_waddr),
      .wr_data (w_wdata),
      .rd_en   (w_re),
      .rd_addr (w_raddr),
      .rd_data (w_rdata)
   );

   // shared comparator: request word when idle, RAM word while scanning
   assign cmp_wake  = (state_ff == ST_SCAN) ? s_rd_wake : req_wake_tick;
   assign cmp_floor = (state_ff == ST_SCAN) ? early_ff  : next_wake_ff;

   swt_cmp u_cmp (
      .wake      (cmp_wake),
      .now       (now_ff),
      .floor_val (cmp_floor),
      .res       (cmp_res)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      next_wake_in = next_wake_ff;
      rd_idx_in    = rd_idx_ff;
      pend_in      = 1'b0;
      keep_in      = keep_ff;
      nw_in        = nw_ff;
      em_idx_in    = em_idx_ff;
      early_in     = early_ff;
      now_in       = now_ff;
      strobe_in    = 1'b0;
      wvalid_in    = 1'b0;
      acc_in       = 1'b0;
      last_in      = 1'b0;
      s_we         = 1'b0;
      s_waddr      = keep_ff[IDX_W-1:0];
      s_wdata      = s_rdata;
      s_re         = 1'b0;
      s_raddr      = rd_idx_ff[IDX_W-1:0];
      w_we         = 1'b0;
      w_waddr      = nw_ff[IDX_W-1:0];
      w_wdata      = s_rd_task;
      w_re         = 1'b0;
      w_raddr      = em_idx_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_action == ACT_SLEEP) begin
                  strobe_in = 1'b1;
                  last_in   = 1'b1;
                  if (cnt_ff < CNT_W'(SLOTS)) begin
                     s_we    = 1'b1;
                     s_waddr = cnt_ff[IDX_W-1:0];
                     s_wdata = {id_ext[TASK_BITS-1:0], req_wake_tick};
                     cnt_in  = cnt_ff + 1'b1;
                     acc_in  = 1'b1;
                     if (cmp_res.lower) begin
                        next_wake_in = req_wake_tick;
                     end
                  end
               end else begin
                  state_in  = ST_SCAN;
                  rd_idx_in = '0;
                  keep_in   = '0;
                  nw_in     = '0;
                  early_in  = TICK_ALL_ONES;
                  now_in    = req_now_tick;
               end
            end
         end
         ST_SCAN: begin
            if (rd_idx_ff < cnt_ff) begin
               s_re      = 1'b1;
               rd_idx_in = rd_idx_ff + 1'b1;
               pend_in   = 1'b1;
            end
            if (pend_ff) begin
               if (cmp_res.due) begin
                  w_we  = 1'b1;
                  nw_in = nw_ff + 1'b1;
               end else begin
                  s_we    = 1'b1;
                  keep_in = keep_ff + 1'b1;
                  if (cmp_res.lower) begin
                     early_in = s_rd_wake;
                  end
               end
            end else if (rd_idx_ff == cnt_ff) begin
               state_in     = ST_EMIT;
               cnt_in       = keep_ff;
               next_wake_in = early_ff;
               em_idx_in    = '0;
            end
         end
         ST_EMIT: begin
            strobe_in = 1'b1;
            if (nw_ff == '0) begin
               last_in  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               w_re      = 1'b1;
               wvalid_in = 1'b1;
               last_in   = (em_idx_ff == nw_ff - 1'b1);
               em_idx_in = em_idx_ff + 1'b1;
               if (em_idx_ff == nw_ff - 1'b1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         next_wake_ff <= TICK_ALL_ONES;
         pend_ff      <= 1'b0;
         strobe_ff    <= 1'b0;
         wvalid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         next_wake_ff <= next_wake_in;
         pend_ff      <= pend_in;
         strobe_ff    <= strobe_in;
         wvalid_ff    <= wvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      keep_ff   <= keep_in;
      nw_ff     <= nw_in;
      em_idx_ff <= em_idx_in;
      early_ff  <= early_in;
      now_ff    <= now_in;
      acc_ff    <= acc_in;
      last_ff   <= last_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = strobe_ff;
   assign rsp_woken_valid   = wvalid_ff;
   assign rsp_woken_task    = wvalid_ff ? wk_ext[TASK_ID_W-1:0] : '0;
   assign rsp_accepted      = acc_ff;
   assign rsp_earliest_wake = next_wake_ff;
   assign rsp_last          = last_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(SLOTS))
      else $error("sleeper count beyond table size");

   a_keep_behind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (keep_ff + nw_ff + CNT_W'(pend_ff) == rd_idx_ff))
      else $error("scan bookkeeping out of step");

   a_valid_strobe: assert property (@(posedge clock) disable iff (reset)
      wvalid_ff |-> strobe_ff)
      else $error("woken task shown without strobe");

   a_tick_scan: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == ACT_TICK) |=> (state_ff == ST_SCAN))
      else $error("tick word did not enter scan");
`endif

endmodule
